[hdl/integer_to_ascii_digits_macros.svh]
// ----------------------------------------------------------------------------
// integer_to_ascii_digits assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_DIGITS_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_MACROS_SVH

// Implication checked every clock outside reset.
`define IAD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_to_ascii_digits: assertion failed");

// Next-cycle implication checked every clock outside reset.
`define IAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_to_ascii_digits: assertion failed");

// Next-cycle implication checked at every clock, reset included.
`define IAD_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("integer_to_ascii_digits: assertion failed");

`endif

[hdl/iad_pkg.sv]
// ----------------------------------------------------------------------------
// iad_pkg
// Types, base codes and digit character mapping for integer_to_ascii_digits.
// ----------------------------------------------------------------------------
`default_nettype none

package iad_pkg;

    // Base codes
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;
    localparam logic [1:0] BASE_BAD = 2'd3;

    // ASCII anchors
    localparam logic [7:0] CHAR_ZERO    = 8'h30;           // '0'
    localparam logic [7:0] CHAR_UPPER_A = 8'h41 - 8'd10;   // 'A' - 10
    localparam logic [7:0] CHAR_LOWER_A = 8'h61 - 8'd10;   // 'a' - 10

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  base_code;
        logic        upper_case;
    } t_in_req;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_char;
    } t_out_req;

    // Control part of a queued conversion job
    typedef struct packed {
        logic [1:0] base_code;
        logic       upper_case;
    } t_job_ctl;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] d8;
        d8 = {4'h0, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + d8;
        end else if (up) begin
            return CHAR_UPPER_A + d8;
        end else begin
            return CHAR_LOWER_A + d8;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/integer_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Unsigned number to ASCII digits in base 2, 10 or 16, one character per pop.
// ----------------------------------------------------------------------------
// A request carries a value, a base code and a hex case flag. The block
// returns the digits most significant first, no leading zeros, a lone '0'
// for zero, with last_char set on the final one; base code 3 is accepted and
// produces nothing. A request is loaded, then shifted out bit by bit for
// binary, digit by digit for hex, and for decimal converted by shift-add-3
// over the value bits, followed by a scan of the decimal digit positions
// (10 at the default width). The scan covers one
// digit position per cycle through the single output register, so a slow
// consumer stretches it. Up to two requests wait in the intake queue while
// the digit engine works; once both are waiting, full holds off push.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_digits import iad_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // request side
    input  wire logic     push,
    output logic          full,
    input  wire t_in_req  i_data,
    // result side
    output logic          empty,
    input  wire logic     pop,
    output t_out_req      o_data
);

    // front to back job handoff
    logic                   job_valid;
    logic [VALUE_WIDTH-1:0] job_value;
    t_job_ctl               job_ctl;
    logic                   job_take;

    // Intake: invalid bases are swallowed here, the rest queued.
    iad_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data      (i_data),
        .o_job_valid (job_valid),
        .o_job_value (job_value),
        .o_job_ctl   (job_ctl),
        .i_take      (job_take)
    );

    // Digit engine with its own output register.
    iad_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job_value (job_value),
        .i_job_ctl   (job_ctl),
        .o_take      (job_take),
        .empty       (empty),
        .pop         (pop),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire

[hdl/iad_front.sv]
// ----------------------------------------------------------------------------
// iad_front
// Request intake: masks the value, drops invalid bases, two-entry job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module iad_front import iad_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire t_in_req                i_data,
    output logic                        o_job_valid,
    output logic [VALUE_WIDTH-1:0]      o_job_value,
    output t_job_ctl                    o_job_ctl,
    input  wire logic                   i_take
);

    logic [VALUE_WIDTH-1:0] r_qval [0:1];
    t_job_ctl               r_qctl [0:1];
    logic                   r_wp, n_wp;
    logic                   r_rp, n_rp;
    logic [1:0]             r_cnt, n_cnt;

    logic [63:0]            in_ext;
    logic                   store;
    logic                   rd;

    assign in_ext = 64'(i_data.value);
    assign full   = (r_cnt == 2'd2);
    assign store  = push && !full && (i_data.base_code != BASE_BAD);
    assign rd     = i_take && (r_cnt != 2'd0);

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job_value = r_qval[r_rp];
    assign o_job_ctl   = r_qctl[r_rp];

    always_comb begin
        n_wp  = r_wp ^ store;
        n_rp  = r_rp ^ rd;
        n_cnt = r_cnt;
        if (store && !rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!store && rd) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_qval[r_wp] <= in_ext[VALUE_WIDTH-1:0];
            r_qctl[r_wp] <= '{base_code: i_data.base_code, upper_case: i_data.upper_case};
        end
    end

endmodule

`default_nettype wire

[hdl/iad_back.sv]
// ----------------------------------------------------------------------------
// iad_back
// Digit engine: shift-add-3 for decimal, digit scan and character output.
// ----------------------------------------------------------------------------
`default_nettype none

module iad_back import iad_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_valid,
    input  wire logic [VALUE_WIDTH-1:0] i_job_value,
    input  wire t_job_ctl               i_job_ctl,
    output logic                        o_take,
    output logic                        empty,
    input  wire logic                   pop,
    output t_out_req                    o_data
);

    localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;   // decimal digits
    localparam int HEXD   = (VALUE_WIDTH + 3) / 4;                // hex digits
    localparam int WW     = 4 * NDIG;                             // work register
    localparam int CW     = $clog2(VALUE_WIDTH + 1);
    localparam int BIN_SH = WW - VALUE_WIDTH;
    localparam int HEX_SH = WW - 4 * HEXD;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [WW-1:0]          r_work, n_work;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_started, n_started;
    logic [1:0]             r_base, n_base;
    logic                   r_upper, n_upper;
    logic                   r_ovalid, n_ovalid;
    t_out_req               r_odata, n_odata;

    logic [WW-1:0]          adj;
    logic [3:0]             digit;
    logic                   is_bin;
    logic                   is_last;
    logic                   emit_now;
    logic                   out_free;
    logic [WW-1:0]          shifted;

    assign empty  = !r_ovalid;
    assign o_data = r_odata;

    // Add-3 correction on every BCD digit, all in parallel
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_work[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_work[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_work[4*i +: 4];
            end
        end
    end

    assign is_bin   = (r_base == BASE_BIN);
    assign digit    = is_bin ? {3'b000, r_work[WW-1]} : r_work[WW-1 -: 4];
    assign shifted  = is_bin ? (r_work << 1) : (r_work << 4);
    assign is_last  = (r_cnt == CW'(1));
    assign emit_now = r_started || (digit != 4'd0) || is_last;
    assign out_free = !r_ovalid || pop;

    always_comb begin
        n_state   = r_state;
        n_work    = r_work;
        n_bin     = r_bin;
        n_cnt     = r_cnt;
        n_started = r_started;
        n_base    = r_base;
        n_upper   = r_upper;
        n_ovalid  = r_ovalid && !pop;
        n_odata   = r_odata;
        o_take    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_take    = 1'b1;
                    n_base    = i_job_ctl.base_code;
                    n_upper   = i_job_ctl.upper_case && (i_job_ctl.base_code == BASE_HEX);
                    n_started = 1'b0;
                    n_bin     = i_job_value;
                    case (i_job_ctl.base_code)
                        BASE_BIN: begin
                            n_work  = WW'(i_job_value) << BIN_SH;
                            n_cnt   = CW'(VALUE_WIDTH);
                            n_state = ST_EMIT;
                        end
                        BASE_HEX: begin
                            n_work  = WW'(i_job_value) << HEX_SH;
                            n_cnt   = CW'(HEXD);
                            n_state = ST_EMIT;
                        end
                        default: begin
                            n_work  = '0;
                            n_cnt   = CW'(VALUE_WIDTH);
                            n_state = ST_CONV;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                n_work = {adj[WW-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin  = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_cnt  = r_cnt - CW'(1);
                if (is_last) begin
                    n_cnt   = CW'(NDIG);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!emit_now || out_free) begin
                    n_work = shifted;
                    n_cnt  = r_cnt - CW'(1);
                    if (emit_now) begin
                        n_started = 1'b1;
                        n_ovalid  = 1'b1;
                        n_odata   = '{ascii_char: digit_char(digit, r_upper),
                                      last_char: is_last};
                    end
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_started <= n_started;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_bin   <= n_bin;
        r_base  <= n_base;
        r_upper <= n_upper;
        r_odata <= n_odata;
    end

endmodule

`default_nettype wire

[hdl/iad_checker.sv]
// ----------------------------------------------------------------------------
// iad_checker
// Port-level checks for integer_to_ascii_digits, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_digits_macros.svh"

module iad_checker import iad_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     push,
    input wire logic     full,
    input wire t_in_req  i_data,
    input wire logic     empty,
    input wire logic     pop,
    input wire t_out_req o_data
);

    logic is_digit;
    logic unused_in;

    assign unused_in = ^i_data;
    assign is_digit  = ((o_data.ascii_char >= 8'h30) && (o_data.ascii_char <= 8'h39)) ||
                       ((o_data.ascii_char >= 8'h41) && (o_data.ascii_char <= 8'h46)) ||
                       ((o_data.ascii_char >= 8'h61) && (o_data.ascii_char <= 8'h66));

    // reset leaves nothing pending and room for requests
    `IAD_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, empty && !full)
    // a waiting result holds until popped
    `IAD_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_data))
    // only digit characters come out
    `IAD_ASSERT_IMPL(a_digit_char, i_clk, i_rst_n, !empty, is_digit || (unused_in && !unused_in))
    // the queue fills only on a push
    `IAD_ASSERT_NEXT(a_full_on_push, i_clk, i_rst_n, !full && !push, !full)

endmodule

bind integer_to_ascii_digits iad_checker u_iad_checker (.*);

`default_nettype wire
